// ----- rtl/rwla_pkg.sv -----
// shared types and codes for the reader-writer lock arbiter
package rwla_pkg;

  localparam int AGENT_W = 3;

  typedef enum logic [1:0] {
    FUNC_RD_START = 2'd0,
    FUNC_RD_DONE  = 2'd1,
    FUNC_WR_START = 2'd2,
    FUNC_WR_DONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_QUEUED   = 3'd0,
    KIND_READ     = 3'd1,
    KIND_WRITE    = 3'd2,
    KIND_RELEASED = 3'd3,
    KIND_ERROR    = 3'd4
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic decide;
    logic wake;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic wake_pending;
    logic wake_more;
  } sts_t;

endpackage

// ----- rtl/rwla_ctrl.sv -----
// sequencing state machine for the reader-writer lock arbiter
module rwla_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  rwla_pkg::sts_t sts,
  output rwla_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEND,
    ST_WAKE
  } state_t;

  state_t state;
  logic   pending;

  always_comb begin
    cmd.capture = (state == ST_IDLE) && in_tready && in_tvalid;
    cmd.decide  = (state == ST_DECIDE);
    cmd.wake    = (state == ST_WAKE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pending    <= 1'b0;
      in_tready  <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_tready && in_tvalid) begin
            in_tready <= 1'b0;
            state     <= ST_DECIDE;
          end else begin
            in_tready <= 1'b1;
          end
        end
        ST_DECIDE: begin
          pending    <= sts.wake_pending;
          out_tvalid <= 1'b1;
          state      <= ST_SEND;
        end
        ST_SEND: begin
          if (out_tready) begin
            out_tvalid <= 1'b0;
            if (pending) begin
              state <= ST_WAKE;
            end else begin
              in_tready <= 1'b1;
              state     <= ST_IDLE;
            end
          end
        end
        ST_WAKE: begin
          pending    <= sts.wake_more;
          out_tvalid <= 1'b1;
          state      <= ST_SEND;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // one request in flight: never taking input while a result is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_capture_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_DECIDE))
    else $error("capture not followed by decision");

  a_wake_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.wake |=> out_tvalid)
    else $error("wake step produced no result");

endmodule

// ----- rtl/rwla_datapath.sv -----
// lock state, request decision and result register
module rwla_datapath #(
  parameter int NUM_AGENTS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rwla_pkg::cmd_t                     cmd,
  output rwla_pkg::sts_t                     sts,
  input  rwla_pkg::func_t                    in_func,
  input  logic [rwla_pkg::AGENT_W-1:0]       in_requester,
  output logic [rwla_pkg::AGENT_W-1:0]       out_agent,
  output rwla_pkg::kind_t                    out_kind,
  output logic                               out_last
);

  localparam int IDX_W = $clog2(NUM_AGENTS);
  localparam logic [NUM_AGENTS-1:0] ONE = {{(NUM_AGENTS-1){1'b0}}, 1'b1};

  // captured request
  rwla_pkg::func_t                req_func;
  logic [rwla_pkg::AGENT_W-1:0]   req_agent;

  // lock state
  logic [NUM_AGENTS-1:0]          rd_act, rd_act_next;
  logic [NUM_AGENTS-1:0]          rd_wait, rd_wait_next;
  logic [NUM_AGENTS-1:0]          wr_wait, wr_wait_next;
  logic                           wr_act, wr_act_next;
  logic [rwla_pkg::AGENT_W-1:0]   owner, owner_next;
  logic                           wake_rd, wake_rd_next;

  logic [rwla_pkg::AGENT_W-1:0]   out_agent_next;
  rwla_pkg::kind_t                out_kind_next;
  logic                           out_last_next;

  logic [NUM_AGENTS-1:0]          req_bit;
  logic                           out_of_range;
  logic                           busy;
  logic [NUM_AGENTS-1:0]          rd_left;
  logic [NUM_AGENTS-1:0]          src;
  logic [IDX_W-1:0]               low_idx;
  logic [NUM_AGENTS-1:0]          low_bit;
  logic                           pend;
  logic                           more;

  assign req_bit      = ONE << req_agent;
  assign out_of_range = int'(req_agent) >= NUM_AGENTS;
  assign busy         = (|((rd_act | rd_wait | wr_wait) & req_bit)) ||
                        (wr_act && (owner == req_agent));
  assign rd_left      = rd_act & ~req_bit;

  // lowest waiting agent of the chosen queue
  assign src = wake_rd ? rd_wait : wr_wait;
  always_comb begin
    low_idx = '0;
    for (int i = NUM_AGENTS - 1; i >= 0; i--) begin
      if (src[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end
  assign low_bit = ONE << low_idx;

  always_comb begin
    rd_act_next    = rd_act;
    rd_wait_next   = rd_wait;
    wr_wait_next   = wr_wait;
    wr_act_next    = wr_act;
    owner_next     = owner;
    wake_rd_next   = wake_rd;
    out_agent_next = req_agent;
    out_kind_next  = rwla_pkg::KIND_ERROR;
    pend           = 1'b0;
    more           = 1'b0;
    if (cmd.decide) begin
      if (!out_of_range) begin
        unique case (req_func)
          rwla_pkg::FUNC_RD_START: begin
            if (!busy) begin
              if (wr_act || (|wr_wait)) begin
                rd_wait_next  = rd_wait | req_bit;
                out_kind_next = rwla_pkg::KIND_QUEUED;
              end else begin
                rd_act_next   = rd_act | req_bit;
                out_kind_next = rwla_pkg::KIND_READ;
              end
            end
          end
          rwla_pkg::FUNC_RD_DONE: begin
            if (|(rd_act & req_bit)) begin
              rd_act_next   = rd_left;
              out_kind_next = rwla_pkg::KIND_RELEASED;
              wake_rd_next  = 1'b0;
              pend          = (rd_left == '0) && !wr_act && (|wr_wait);
            end
          end
          rwla_pkg::FUNC_WR_START: begin
            if (!busy) begin
              if (wr_act || (|rd_act)) begin
                wr_wait_next  = wr_wait | req_bit;
                out_kind_next = rwla_pkg::KIND_QUEUED;
              end else begin
                wr_act_next   = 1'b1;
                owner_next    = req_agent;
                out_kind_next = rwla_pkg::KIND_WRITE;
              end
            end
          end
          rwla_pkg::FUNC_WR_DONE: begin
            if (wr_act && (owner == req_agent)) begin
              wr_act_next   = 1'b0;
              out_kind_next = rwla_pkg::KIND_RELEASED;
              if (|wr_wait) begin
                wake_rd_next = 1'b0;
                pend         = 1'b1;
              end else begin
                wake_rd_next = 1'b1;
                pend         = |rd_wait;
              end
            end
          end
          default: begin
            out_kind_next = rwla_pkg::KIND_ERROR;
          end
        endcase
      end
    end else if (cmd.wake) begin
      out_agent_next = rwla_pkg::AGENT_W'(low_idx);
      if (wake_rd) begin
        rd_wait_next  = rd_wait & ~low_bit;
        rd_act_next   = rd_act | low_bit;
        out_kind_next = rwla_pkg::KIND_READ;
        more          = |(rd_wait & ~low_bit);
      end else begin
        wr_wait_next  = wr_wait & ~low_bit;
        wr_act_next   = 1'b1;
        owner_next    = rwla_pkg::AGENT_W'(low_idx);
        out_kind_next = rwla_pkg::KIND_WRITE;
      end
    end
    out_last_next = cmd.decide ? !pend : !more;
  end

  always_comb begin
    sts.wake_pending = pend;
    sts.wake_more    = more;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_act  <= '0;
      rd_wait <= '0;
      wr_wait <= '0;
      wr_act  <= 1'b0;
      owner   <= '0;
      wake_rd <= 1'b0;
    end else begin
      rd_act  <= rd_act_next;
      rd_wait <= rd_wait_next;
      wr_wait <= wr_wait_next;
      wr_act  <= wr_act_next;
      owner   <= owner_next;
      wake_rd <= wake_rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func  <= in_func;
      req_agent <= in_requester;
    end
    if (cmd.decide || cmd.wake) begin
      out_agent <= out_agent_next;
      out_kind  <= out_kind_next;
      out_last  <= out_last_next;
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr_act && (|rd_act)))
    else $error("writer and readers active together");

  a_rd_disjoint: assert property (@(posedge clk) disable iff (rst)
    ((rd_act & rd_wait) == '0) && ((rd_wait & wr_wait) == '0))
    else $error("agent both held and queued");

  a_wr_disjoint: assert property (@(posedge clk) disable iff (rst)
    (rd_act & wr_wait) == '0)
    else $error("active reader also queued for write");

endmodule

// ----- rtl/writer_preferred_rw_lock_arbiter_top.sv -----
// top level of the writer-preferred reader-writer lock arbiter
//
//  channel   dir  signals                                  contents
//  s_axis    in   tvalid tready tdata[7:0] tuser[1:0]      request: requester in tdata, func in tuser
//  m_axis    out  tvalid tready tdata[7:0] tuser[2:0] tlast result: agent in tdata, kind in tuser
//
// each request is accepted, then decided; each result is shown in turn, and
// every result after the first is preceded by its own wake-up step. a request
// gives at most eight results (writer release waking every queued reader, one
// priority-encoder step per reader).
// one request is in flight at a time; s_axis_tready is low until its last
// result has been taken. a stalled m_axis holds the result and the sequence.
// rst is synchronous, active high, and clears all lock and queue state.
module writer_preferred_rw_lock_arbiter_top #(
  parameter int NUM_AGENTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [2:0] requester, [7:3] zero
  input  logic [1:0] s_axis_tuser,   // [1:0] func
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [2:0] agent, [7:3] zero
  output logic [2:0] m_axis_tuser,   // [2:0] kind
  output logic       m_axis_tlast
);

  rwla_pkg::cmd_t                 cmd;
  rwla_pkg::sts_t                 sts;
  logic [rwla_pkg::AGENT_W-1:0]   res_agent;
  rwla_pkg::kind_t                res_kind;
  rwla_pkg::func_t                req_func;

  // unpack the request
  assign req_func = rwla_pkg::func_t'(s_axis_tuser);

  // sequencing: accept, decide, show each result, step through wake-ups
  rwla_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // lock and queue masks, grant decision, result register
  rwla_datapath #(
    .NUM_AGENTS (NUM_AGENTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (req_func),
    .in_requester (s_axis_tdata[2:0]),
    .out_agent    (res_agent),
    .out_kind     (res_kind),
    .out_last     (m_axis_tlast)
  );

  // pack the result, agent zero filled to a whole byte, kind on tuser
  assign m_axis_tdata = {5'b00000, res_agent};
  assign m_axis_tuser = res_kind;

endmodule
